/* src/mcfc_pkg.sv */
`default_nettype none
package mcfc_pkg;
   localparam int MAX_PAYLOAD_DEF = 64;
   localparam int CONTROL_LEN_DEF = 21;
   localparam int LEGACY_LEN = 20;
   localparam int COMMAND_LEN_DEF = 2;
   localparam logic [28:0] CTRL_BASE = 29'h100;
   localparam logic [28:0] CMD_BASE = 29'h110;
   localparam logic [31:0] TIMEOUT_DEFAULT = 32'd100;
   localparam logic [7:0] CODE_ENABLE = 8'd1;
   localparam logic [7:0] CODE_DISABLE = 8'd2;
   localparam logic [7:0] CODE_CLEAR = 8'd3;
   localparam int F_RANGE = 0;
   localparam int F_TIMEOUT = 1;
   localparam int F_BAD = 2;

   localparam logic [2:0] REG_NODE = 3'd0;
   localparam logic [2:0] REG_TIMEOUT = 3'd1;
   localparam logic [2:0] REG_POS_MIN = 3'd2;
   localparam logic [2:0] REG_POS_MAX = 3'd3;
   localparam logic [2:0] REG_VEL = 3'd4;
   localparam logic [2:0] REG_STIFF = 3'd5;
   localparam logic [2:0] REG_DAMP = 3'd6;
   localparam logic [2:0] REG_TORQUE = 3'd7;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0, OP_CONTROL = 3'd1, OP_RANGE_FAULT = 3'd2, OP_ENABLE = 3'd3,
      OP_DISABLE = 3'd4, OP_CLEAR = 3'd5, OP_BAD = 3'd6, OP_TICK = 3'd7
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  mode;
      logic [31:0] pos;
      logic [31:0] vel;
      logic [31:0] stiff;
      logic [31:0] damp;
      logic [31:0] torque;
      logic [31:0] now;
   } cmd_type;

   // IEEE less-than on binary32 patterns; false when either is NaN
   function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
      logic a_nan, b_nan, a_zero, b_zero, res;
      a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      if (a_nan || b_nan || (a_zero && b_zero)) res = 1'b0;
      else if (a[31] != b[31]) res = a[31];
      else if (!a[31]) res = a[30:0] < b[30:0];
      else res = a[30:0] > b[30:0];
      return res;
   endfunction
endpackage
`default_nettype wire

/* src/mcfc_front.sv */
`default_nettype none
module mcfc_front #(
   parameter int MAX_PAYLOAD = mcfc_pkg::MAX_PAYLOAD_DEF,
   parameter int CONTROL_LEN = mcfc_pkg::CONTROL_LEN_DEF,
   parameter int COMMAND_LEN = mcfc_pkg::COMMAND_LEN_DEF
) (
   input  wire logic        item_kind,
   input  wire logic [28:0] frame_ident,
   input  wire logic        extended_flag,
   input  wire logic [7:0]  data_length,
   input  wire logic [31:0] word_zero,
   input  wire logic [31:0] word_one,
   input  wire logic [31:0] word_two,
   input  wire logic [31:0] word_three,
   input  wire logic [31:0] word_four,
   input  wire logic [7:0]  mode_byte,
   input  wire logic [31:0] time_now,
   input  wire logic [7:0]  node_id,
   input  wire logic [31:0] pos_min,
   input  wire logic [31:0] pos_max,
   input  wire logic [31:0] vel_lim,
   input  wire logic [31:0] stiff_lim,
   input  wire logic [31:0] damp_lim,
   input  wire logic [31:0] torque_lim,
   output mcfc_pkg::cmd_type cmd
);
   localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);
   localparam logic [7:0] CtrlLen = 8'(CONTROL_LEN);
   localparam logic [7:0] LegLen = 8'(mcfc_pkg::LEGACY_LEN);
   localparam logic [7:0] CmdLen = 8'(COMMAND_LEN);

   logic [7:0]  mode;
   logic        is_ctrl, is_cmd, fin, ok, pos_chk;
   logic [31:0] vabs, tabs;

   // classify and range-check the request
   always_comb begin
      is_ctrl = !extended_flag && (data_length <= MaxLen) &&
                (frame_ident == mcfc_pkg::CTRL_BASE + {21'd0, node_id}) &&
                (data_length == CtrlLen || data_length == LegLen);
      is_cmd = !extended_flag && (data_length <= MaxLen) && !is_ctrl &&
               (frame_ident == mcfc_pkg::CMD_BASE + {21'd0, node_id}) &&
               (data_length == CmdLen);
      mode = (data_length >= CtrlLen) ? mode_byte : 8'd0;
      fin = (word_zero[30:23] != 8'hff) && (word_one[30:23] != 8'hff) &&
            (word_two[30:23] != 8'hff) && (word_three[30:23] != 8'hff) &&
            (word_four[30:23] != 8'hff);
      vabs = {1'b0, word_one[30:0]};
      tabs = {1'b0, word_four[30:0]};
      pos_chk = (mode == 8'd0 || mode == 8'd3) &&
                (mcfc_pkg::f_lt(word_zero, pos_min) || mcfc_pkg::f_lt(pos_max, word_zero));
      ok = (mode <= 8'd3) && fin && !pos_chk && !mcfc_pkg::f_lt(vel_lim, vabs) &&
           !mcfc_pkg::f_lt(word_two, 32'd0) && !mcfc_pkg::f_lt(stiff_lim, word_two) &&
           !mcfc_pkg::f_lt(word_three, 32'd0) && !mcfc_pkg::f_lt(damp_lim, word_three) &&
           !mcfc_pkg::f_lt(torque_lim, tabs);
      cmd.mode = mode[1:0];
      cmd.pos = word_zero;
      cmd.vel = word_one;
      cmd.stiff = word_two;
      cmd.damp = word_three;
      cmd.torque = word_four;
      cmd.now = time_now;
      if (item_kind) cmd.op = mcfc_pkg::OP_TICK;
      else if (is_ctrl) cmd.op = ok ? mcfc_pkg::OP_CONTROL : mcfc_pkg::OP_RANGE_FAULT;
      else if (is_cmd) begin
         case (word_zero[7:0])
            mcfc_pkg::CODE_ENABLE:  cmd.op = mcfc_pkg::OP_ENABLE;
            mcfc_pkg::CODE_DISABLE: cmd.op = mcfc_pkg::OP_DISABLE;
            mcfc_pkg::CODE_CLEAR:   cmd.op = mcfc_pkg::OP_CLEAR;
            default:                cmd.op = mcfc_pkg::OP_BAD;
         endcase
      end else cmd.op = mcfc_pkg::OP_NONE;
   end
endmodule
`default_nettype wire

/* src/mcfc_queue.sv */
`default_nettype none
module mcfc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  mcfc_pkg::cmd_type      in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output mcfc_pkg::cmd_type      out_data
);
   mcfc_pkg::cmd_type mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // hold two decoded requests
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule
`default_nettype wire

/* src/mcfc_back.sv */
`default_nettype none
module mcfc_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         cmd_valid,
   output logic              cmd_ready,
   input  mcfc_pkg::cmd_type cmd,
   input  wire logic [31:0]  timeout_ms,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_accepted,
   output logic              rsp_drive_enabled,
   output logic              rsp_link_alive,
   output logic              rsp_clear_request,
   output logic [2:0]        rsp_fault_flags,
   output logic [1:0]        rsp_held_mode,
   output logic [31:0]       rsp_held_position,
   output logic [31:0]       rsp_held_velocity,
   output logic [31:0]       rsp_held_stiffness,
   output logic [31:0]       rsp_held_damping,
   output logic [31:0]       rsp_held_torque
);
   logic        en_ff, en_in, clr_ff, clr_in, acc_in, valid_ff, take;
   logic [2:0]  flt_ff, flt_in;
   logic [1:0]  mode_ff, mode_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] w_ff [5];
   logic [31:0] w_in [5];

   assign cmd_ready = !valid_ff || rsp_ready;
   assign take = cmd_valid && cmd_ready;
   assign rsp_valid = valid_ff;

   // apply one request to the state
   always_comb begin
      en_in = en_ff; clr_in = clr_ff; flt_in = flt_ff; mode_in = mode_ff;
      last_in = last_ff; acc_in = 1'b0;
      for (int i = 0; i < 5; i++) w_in[i] = w_ff[i];
      case (cmd.op)
         mcfc_pkg::OP_CONTROL: begin
            w_in[0] = cmd.pos; w_in[1] = cmd.vel; w_in[2] = cmd.stiff;
            w_in[3] = cmd.damp; w_in[4] = cmd.torque;
            mode_in = cmd.mode; en_in = 1'b1; clr_in = 1'b0;
            last_in = cmd.now; flt_in[mcfc_pkg::F_TIMEOUT] = 1'b0; acc_in = 1'b1;
         end
         mcfc_pkg::OP_RANGE_FAULT: flt_in[mcfc_pkg::F_RANGE] = 1'b1;
         mcfc_pkg::OP_ENABLE: begin en_in = 1'b1; acc_in = 1'b1; end
         mcfc_pkg::OP_DISABLE: begin en_in = 1'b0; acc_in = 1'b1; end
         mcfc_pkg::OP_CLEAR: begin clr_in = 1'b1; flt_in = 3'd0; acc_in = 1'b1; end
         mcfc_pkg::OP_BAD: flt_in[mcfc_pkg::F_BAD] = 1'b1;
         mcfc_pkg::OP_TICK: begin
            if (en_ff && ((cmd.now - last_ff) > timeout_ms)) begin
               en_in = 1'b0; flt_in[mcfc_pkg::F_TIMEOUT] = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // advance state and load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0; clr_ff <= 1'b0; flt_ff <= 3'd0; mode_ff <= 2'd0;
         last_ff <= 32'd0; valid_ff <= 1'b0;
         for (int i = 0; i < 5; i++) w_ff[i] <= 32'd0;
      end else begin
         if (take) begin
            en_ff <= en_in; clr_ff <= clr_in; flt_ff <= flt_in; mode_ff <= mode_in;
            last_ff <= last_in;
            for (int i = 0; i < 5; i++) w_ff[i] <= w_in[i];
            rsp_accepted <= acc_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   assign rsp_drive_enabled = en_ff;
   assign rsp_link_alive = en_ff && !flt_ff[mcfc_pkg::F_TIMEOUT];
   assign rsp_clear_request = clr_ff;
   assign rsp_fault_flags = flt_ff;
   assign rsp_held_mode = mode_ff;
   assign rsp_held_position = w_ff[0];
   assign rsp_held_velocity = w_ff[1];
   assign rsp_held_stiffness = w_ff[2];
   assign rsp_held_damping = w_ff[3];
   assign rsp_held_torque = w_ff[4];
endmodule
`default_nettype wire

/* src/motor_command_frame_checker.sv */
// A request passes through the queue, then the result register, before its response shows.
// Throughput: one request per cycle while not stalled; the back end applies one request per cycle to the state.
// A two-entry queue separates decode from state update; the result register holds while stalled.
// Reset (synchronous, active high) restores register defaults and clears state and queue.
`default_nettype none
module motor_command_frame_checker #(
   parameter int MAX_PAYLOAD = mcfc_pkg::MAX_PAYLOAD_DEF,
   parameter int CONTROL_LEN = mcfc_pkg::CONTROL_LEN_DEF,
   parameter int COMMAND_LEN = mcfc_pkg::COMMAND_LEN_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_item_kind,
   input  wire logic [28:0] req_frame_ident,
   input  wire logic        req_extended_flag,
   input  wire logic [7:0]  req_data_length,
   input  wire logic [31:0] req_word_zero,
   input  wire logic [31:0] req_word_one,
   input  wire logic [31:0] req_word_two,
   input  wire logic [31:0] req_word_three,
   input  wire logic [31:0] req_word_four,
   input  wire logic [7:0]  req_mode_byte,
   input  wire logic [31:0] req_time_now,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_accepted,
   output logic             rsp_drive_enabled,
   output logic             rsp_link_alive,
   output logic             rsp_clear_request,
   output logic [2:0]       rsp_fault_flags,
   output logic [1:0]       rsp_held_mode,
   output logic [31:0]      rsp_held_position,
   output logic [31:0]      rsp_held_velocity,
   output logic [31:0]      rsp_held_stiffness,
   output logic [31:0]      rsp_held_damping,
   output logic [31:0]      rsp_held_torque
);
   logic [7:0]  node_ff;
   logic [31:0] tmo_ff, pmin_ff, pmax_ff, vel_ff, stf_ff, dmp_ff, tq_ff;
   mcfc_pkg::cmd_type dec, q_data;
   logic q_valid, q_ready;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= 8'd0; tmo_ff <= mcfc_pkg::TIMEOUT_DEFAULT;
         pmin_ff <= 32'd3226013659; pmax_ff <= 32'd1078530011;
         vel_ff <= 32'd1101004800; stf_ff <= 32'd1120403456;
         dmp_ff <= 32'd1092616192; tq_ff <= 32'd1090519040;
      end else if (csr_write_enable) begin
         case (csr_index)
            mcfc_pkg::REG_NODE: node_ff <= csr_data[7:0];
            mcfc_pkg::REG_TIMEOUT:
               tmo_ff <= (csr_data == 32'd0) ? mcfc_pkg::TIMEOUT_DEFAULT : csr_data;
            mcfc_pkg::REG_POS_MIN: pmin_ff <= csr_data;
            mcfc_pkg::REG_POS_MAX: pmax_ff <= csr_data;
            mcfc_pkg::REG_VEL: vel_ff <= csr_data;
            mcfc_pkg::REG_STIFF: stf_ff <= csr_data;
            mcfc_pkg::REG_DAMP: dmp_ff <= csr_data;
            mcfc_pkg::REG_TORQUE: tq_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mcfc_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .CONTROL_LEN(CONTROL_LEN),
                .COMMAND_LEN(COMMAND_LEN)) u_front (
      .item_kind(req_item_kind), .frame_ident(req_frame_ident),
      .extended_flag(req_extended_flag), .data_length(req_data_length),
      .word_zero(req_word_zero), .word_one(req_word_one), .word_two(req_word_two),
      .word_three(req_word_three), .word_four(req_word_four),
      .mode_byte(req_mode_byte), .time_now(req_time_now), .node_id(node_ff),
      .pos_min(pmin_ff), .pos_max(pmax_ff), .vel_lim(vel_ff), .stiff_lim(stf_ff),
      .damp_lim(dmp_ff), .torque_lim(tq_ff), .cmd(dec));

   mcfc_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_data(dec), .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data));

   mcfc_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(q_valid), .cmd_ready(q_ready),
      .cmd(q_data), .timeout_ms(tmo_ff), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted), .rsp_drive_enabled(rsp_drive_enabled),
      .rsp_link_alive(rsp_link_alive), .rsp_clear_request(rsp_clear_request),
      .rsp_fault_flags(rsp_fault_flags), .rsp_held_mode(rsp_held_mode),
      .rsp_held_position(rsp_held_position), .rsp_held_velocity(rsp_held_velocity),
      .rsp_held_stiffness(rsp_held_stiffness), .rsp_held_damping(rsp_held_damping),
      .rsp_held_torque(rsp_held_torque));
endmodule
`default_nettype wire

/* src/mcfc_checker.sv */
`default_nettype none
module mcfc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_accepted,
   input wire logic       rsp_drive_enabled,
   input wire logic       rsp_link_alive,
   input wire logic [2:0] rsp_fault_flags
);
   // link alive only when enabled without timeout
   a_alive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_link_alive ==
                     (rsp_drive_enabled && !rsp_fault_flags[mcfc_pkg::F_TIMEOUT])))
      else $error("link_alive inconsistent");
   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fault_flags) &&
                                  $stable(rsp_accepted))
      else $error("response changed while stalled");
   // no response straight out of reset
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response after reset");
endmodule

bind motor_command_frame_checker mcfc_checker u_mcfc_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_accepted(rsp_accepted), .rsp_drive_enabled(rsp_drive_enabled),
   .rsp_link_alive(rsp_link_alive), .rsp_fault_flags(rsp_fault_flags));
`default_nettype wire
